@@ rtl/swmm_pkg.sv @@
// Shared widths and field layout for the sliding window min/max/mean block.
package swmm_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned OUT_W     = 3 * DATA_W + CNT_OUT_W;
  localparam int unsigned OUT_BYTES = (OUT_W + 7) / 8;
  localparam int unsigned OUT_TDATA_W = OUT_BYTES * 8;

  typedef logic [DATA_W-1:0] sample_t;

endpackage

@@ rtl/sliding_window_min_max_mean_top.sv @@
// Top level of the sliding window min/max/mean block.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata  : sample_ns
//  out_    | out | out_tvalid/out_tready| out_tdata : window_min, window_max, window_mean,
//          |     |                      |             sample_count
//
// One word at a time. A word that evicts no extremum waits for the serial mean
// divider (TW = 32 + log2(WINDOW) bits of the divider, 38 at WINDOW = 64). An
// evicted extremum also rotates the cell chain once, alongside the divider.
// Synchronous active-low reset empties the window; no clearing pass. in_tready
// is low while a word is in progress; a finished result waits in the output
// register.
module sliding_window_min_max_mean_top
  import swmm_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // [31:0] sample_ns
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] window_min, [63:32] window_max,
                                             // [95:64] window_mean, [102:96] sample_count
);

  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned TW = DATA_W + $clog2(WINDOW);

  typedef enum logic [0:0] {IDLE, RUN} state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_r;
  logic [TW-1:0] total_r;
  sample_t       min_r;
  sample_t       max_r;
  logic          out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  sample_t       cell_q [WINDOW];
  logic          shift_en;
  sample_t       chain_in;
  sample_t       leaving;
  logic          accept;
  logic          full;
  logic          rescan;
  logic [TW-1:0] total_nxt;
  logic [CW-1:0] count_nxt;
  logic          div_done;
  logic [TW-1:0] quotient;
  logic          finish;
  sample_t       sample;

  assign sample   = in_tdata;
  assign accept   = in_tvalid && in_tready;
  assign full     = (count_r == CW'(WINDOW));
  assign leaving  = cell_q[WINDOW-1];
  assign rescan   = full && ((leaving == min_r) || (leaving == max_r));
  assign shift_en = accept || (scan_r != '0);
  assign chain_in = accept ? sample : leaving;

  always_comb begin
    total_nxt = total_r + TW'(sample);
    count_nxt = count_r + 1'b1;
    if (full) begin
      total_nxt = total_r - TW'(leaving) + TW'(sample);
      count_nxt = count_r;
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (chain_in),
        .q        (cell_q[i])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  swmm_div #(
    .TW (TW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (total_nxt),
    .divisor  (count_nxt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign finish = (state_r == RUN) && (scan_r == '0) && div_done &&
                  (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      total_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (accept) begin
            state_r <= RUN;
            total_r <= total_nxt;
            count_r <= count_nxt;
            if (rescan) begin
              min_r  <= '1;
              max_r  <= '0;
              scan_r <= CW'(WINDOW);
            end else begin
              if (sample < min_r) min_r <= sample;
              if (sample > max_r) max_r <= sample;
            end
          end
        end
        RUN: begin
          if (scan_r != '0) begin
            scan_r <= scan_r - 1'b1;
            if (leaving < min_r) min_r <= leaving;
            if (leaving > max_r) max_r <= leaving;
          end
          if (finish) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= OUT_TDATA_W'({CNT_OUT_W'(count_r), quotient[DATA_W-1:0], max_r, min_r});
    end
  end

  assign in_tready  = (state_r == IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/swmm_cell.sv @@
// One window cell: holds a single sample and passes it to the next cell on shift.
module swmm_cell
  import swmm_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  sample_t d_in,
  output sample_t q
);

  sample_t val_r;
  sample_t val_nxt;

  always_comb begin
    val_nxt = shift_en ? d_in : val_r;
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

@@ rtl/swmm_div.sv @@
// Serial restoring divider, one quotient bit per cycle, for the window mean.
module swmm_div #(
  parameter int unsigned TW = 38,
  parameter int unsigned CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [TW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [TW-1:0] quotient
);

  localparam int unsigned SW = $clog2(TW + 1);

  logic [TW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [CW:0]   trial;
  logic          fits;

  always_comb begin
    trial   = {rem_r, quo_r[TW-1]};
    fits    = (trial >= {1'b0, dvs_r});
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = SW'(TW);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[TW-2:0], fits};
      rem_nxt = fits ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = (cnt_r == '0) && !start;
  assign quotient = quo_r;

endmodule

@@ rtl/swmm_chk.sv @@
// Port-level checker for the sliding window min/max/mean block, with its bind.
module swmm_chk
  import swmm_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  sample_t w_min, w_max, w_mean;
  logic [CNT_OUT_W-1:0] w_count;

  assign w_min   = out_tdata[DATA_W-1:0];
  assign w_max   = out_tdata[2*DATA_W-1:DATA_W];
  assign w_mean  = out_tdata[3*DATA_W-1:2*DATA_W];
  assign w_count = out_tdata[3*DATA_W+CNT_OUT_W-1:3*DATA_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> w_min <= w_max)
    else $error("window minimum above maximum");

  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (w_mean >= w_min) && (w_mean <= w_max))
    else $error("window mean outside min/max");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(w_count) <= WINDOW))
    else $error("sample count above window size");

endmodule

bind sliding_window_min_max_mean_top swmm_chk #(.WINDOW(WINDOW)) u_swmm_chk (.*);

@@ dv/sliding_window_min_max_mean_top_tb.sv @@
// Self-checking stream testbench for the sliding window min/max/mean block.
module sliding_window_min_max_mean_top_tb;
  import swmm_pkg::*;

  localparam int unsigned WINDOW          = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = 150;

  typedef struct {
    sample_t        lo;
    sample_t        hi;
    sample_t        mean;
    logic [CNT_OUT_W-1:0] count;
  } window_stats_t;

  typedef enum int {
    MODE_FULL,
    MODE_NARROW,
    MODE_TOP,
    MODE_RAMP_UP,
    MODE_RAMP_DOWN,
    MODE_EXTREME
  } sample_mode_e;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sample_t       win_ring [WINDOW];
  int unsigned   win_oldest;
  int unsigned   win_held;
  logic [37:0]   win_total;
  sample_t       win_lo;
  sample_t       win_hi;

  window_stats_t expected_stats [$];
  int unsigned   error_count   = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   hold_req      = 0;
  int unsigned   hold_seen     = 0;
  int unsigned   hold_left     = 0;
  int unsigned   quiet_cycles  = 0;
  sample_t       ramp_value    = '0;

  sliding_window_min_max_mean_top #(.WINDOW(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_window();
    win_oldest = 0;
    win_held   = 0;
    win_total  = '0;
    win_lo     = '1;
    win_hi     = '0;
  endfunction

  function automatic window_stats_t fold_sample(input sample_t s);
    window_stats_t r;
    sample_t       leaving;
    sample_t       v;
    int unsigned   slot;
    logic [63:0]   quot;
    if (win_held >= WINDOW) begin
      leaving   = win_ring[win_oldest];
      win_total = win_total - leaving;
      win_held  = WINDOW - 1;
      if (leaving == win_lo || leaving == win_hi) begin
        win_lo = '1;
        win_hi = '0;
        for (int i = 1; i < WINDOW; i++) begin
          v = win_ring[(win_oldest + i) % WINDOW];
          if (v < win_lo) win_lo = v;
          if (v > win_hi) win_hi = v;
        end
      end
      slot       = win_oldest;
      win_oldest = (win_oldest + 1) % WINDOW;
    end else begin
      slot = (win_oldest + win_held) % WINDOW;
    end
    win_ring[slot] = s;
    if (s < win_lo) win_lo = s;
    if (s > win_hi) win_hi = s;
    win_total = win_total + s;
    win_held  = win_held + 1;
    quot      = 64'(win_total) / win_held;
    r.lo      = win_lo;
    r.hi      = win_hi;
    r.mean    = quot[31:0];
    r.count   = win_held[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic sample_t next_sample(input sample_mode_e mode);
    case (mode)
      MODE_NARROW: begin
        return sample_t'($urandom_range(0, 7));
      end
      MODE_TOP: begin
        return ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(1, 3)
                                           : 32'hFFFF_FFFF;
      end
      MODE_RAMP_UP: begin
        ramp_value = ramp_value + $urandom_range(1, 4096);
        return ramp_value;
      end
      MODE_RAMP_DOWN: begin
        ramp_value = ramp_value - $urandom_range(1, 4096);
        return ramp_value;
      end
      MODE_EXTREME: begin
        return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    expected_stats.insert(expected_stats.size(), fold_sample(s));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_items(input int unsigned n);
    int unsigned  left;
    sample_mode_e mode;
    left = 0;
    mode = MODE_FULL;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        mode       = sample_mode_e'($urandom_range(0, int'(MODE_EXTREME)));
        left       = $urandom_range(8, 100);
        ramp_value = sample_t'($urandom);
      end
      send_sample(next_sample(mode));
      left--;
    end
  endtask

  task automatic test_field_extremes();
    sample_t seq [$];
    seq = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
            32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0000_1234, 32'h0000_1234, 32'h0000_1234, 32'h0000_1234,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
            32'h0F0F_F0F0, 32'hF0F0_0F0F};
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    foreach (seq[i]) send_sample(seq[i]);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    run_random_items(350);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 60;
    recv_stall_pct <= 0;
    run_random_items(350);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct <= 60;
    run_random_items(350);
    wait_drained();
  endtask

  task automatic test_mixed_idling();
    send_idle_pct = 18;
    recv_stall_pct <= 18;
    run_random_items(350);
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= hold_req + 1;
    run_random_items(40);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_OFF_CYCLES;
      hold_seen  <= hold_req;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stats.size() == 0) begin
        $error("unexpected result word 0x%026h", out_tdata);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        check_field("window_min", want.lo, out_tdata[31:0]);
        check_field("window_max", want.hi, out_tdata[63:32]);
        check_field("window_mean", want.mean, out_tdata[95:64]);
        check_field("sample_count", 32'(want.count), 32'(out_tdata[102:96]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_output_hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
